>>> sv/bpc_pkg.sv
// shared types, constants and helpers for the pressure compensation block
`default_nettype none
package bpc_pkg;

	localparam int DW = 32;
	localparam int CW = $clog2(DW);

	localparam logic [2:0] FAIL_LIMIT = 3'd5;
	localparam logic [2:0] FAIL_MAX = 3'd7;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_WARN = 2'd1;
	localparam logic [1:0] ST_REPEAT = 2'd2;

	localparam logic [2:0] CFG_CAL_A = 3'd0;
	localparam logic [2:0] CFG_CAL_B = 3'd1;
	localparam logic [2:0] CFG_CAL_C = 3'd2;
	localparam logic [2:0] CFG_CAL_D = 3'd3;
	localparam logic [2:0] CFG_OSS = 3'd4;

	typedef struct packed {
		logic [18:0] raw_pressure;
		logic [15:0] raw_temp;
		logic        temp_fresh;
	} in_item_t;

	typedef struct packed {
		logic signed [10:0] temperature;
		logic [16:0]        pressure;
		logic [1:0]         status;
	} out_item_t;

	function automatic logic signed [DW-1:0] sx16(input logic [15:0] v);
		sx16 = DW'($signed(v));
	endfunction

endpackage
`default_nettype wire

>>> sv/bpc_mul.sv
// bit-serial multiplier, low word of the product, one multiplier bit per cycle
`default_nettype none
module bpc_mul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [bpc_pkg::DW-1:0] a,
	input  wire logic [bpc_pkg::DW-1:0] b,
	output logic                       done,
	output logic [bpc_pkg::DW-1:0]      prod
);
	import bpc_pkg::*;

	logic [DW-1:0] a_q, b_q, acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= CW'(cnt_q + 1'b1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (b_q[0] ? a_q : '0);
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

>>> sv/bpc_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module bpc_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [bpc_pkg::DW-1:0] num,
	input  wire logic [bpc_pkg::DW-1:0] den,
	output logic                       done,
	output logic [bpc_pkg::DW-1:0]      quo
);
	import bpc_pkg::*;

	logic [DW-1:0] n_q, d_q, r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial;

	assign trial = {r_q, n_q[DW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= CW'(cnt_q + 1'b1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the numerator register
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				r_q <= trial[DW-1:0];
				n_q <= {n_q[DW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DW-2:0], n_q[DW-1]};
				n_q <= {n_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = n_q;
endmodule
`default_nettype wire

>>> sv/baro_temp_pressure_compensation_top.sv
// Barometric temperature and pressure compensation. One raw pressure sample
// (with an optional fresh raw temperature) is taken per transfer and gives one
// result: last good temperature in tenths of a degree, last good pressure in
// pascals and a status. A result is loaded into the output register after
// thirteen steps, each an issue state and a wait for the one-bit-per-cycle
// iterations of the shared bit-serial multiplier (eleven products) or the
// serial divider (two quotients); a zero denominator ends an item early. The
// next input transfer is taken only once the block is back in its idle state,
// so items never overlap. A finished result waits in the output register
// while the next item is accepted. A result that cannot be loaded because the
// previous one is still stalled holds the block until it can. Calibration
// registers must be written through the cfg port only while the block is idle;
// the block does not enforce this. cfg_ready is always high.
`default_nettype none
module baro_temp_pressure_compensation_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire bpc_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output bpc_pkg::out_item_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [47:0]        cfg_data
);
	import bpc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ISSUE  = 4'b0010,
		S_WAIT   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		OP_X1T, OP_X2T, OP_SQ, OP_X1P, OP_X2P, OP_X1Q, OP_X2Q,
		OP_B4, OP_B7, OP_Q, OP_PP, OP_P1, OP_P2
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic [47:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q, cal_d_q;
	logic [1:0]  oss_q;
	logic [15:0] held_q;
	logic [2:0]  fail_q;
	logic signed [10:0] good_t_q;
	logic [16:0] good_p_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [18:0] up_q;
	logic        bad_q;
	logic signed [31:0] x1_q, den_q, b6_q, sq_q, tmp_q, b3_q, p_q, t_q;
	logic [31:0] b4_q, b7_q;

	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0] ac4, ac5, ac6;

	assign ac1 = sx16(cal_a_q[47:32]);
	assign ac2 = sx16(cal_a_q[31:16]);
	assign ac3 = sx16(cal_a_q[15:0]);
	assign ac4 = {16'd0, cal_b_q[47:32]};
	assign ac5 = {16'd0, cal_b_q[31:16]};
	assign ac6 = {16'd0, cal_b_q[15:0]};
	assign b1 = sx16(cal_c_q[31:16]);
	assign b2 = sx16(cal_c_q[15:0]);
	assign mc = sx16(cal_d_q[31:16]);
	assign md = sx16(cal_d_q[15:0]);

	// unit operands
	logic [31:0] mul_a, mul_b, div_n, div_d, mres, dres;
	logic        use_div, mul_start, div_start, mul_done, div_done, unit_done;
	logic signed [31:0] mcs, mres_s, pshr;

	assign mcs = mc <<< 11;
	assign pshr = p_q >>> 8;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		use_div = 1'b0;
		case (op_q)
			OP_X1T: begin
				mul_a = {16'd0, held_q} - ac6;
				mul_b = ac5;
			end
			OP_X2T: begin
				use_div = 1'b1;
				div_n = mcs[31] ? 32'(-mcs) : mcs;
				div_d = den_q[31] ? 32'(-den_q) : den_q;
			end
			OP_SQ: begin
				mul_a = b6_q;
				mul_b = b6_q;
			end
			OP_X1P: begin
				mul_a = b2;
				mul_b = sq_q;
			end
			OP_X2P: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			OP_X1Q: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			OP_X2Q: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			OP_B4: begin
				mul_a = ac4;
				mul_b = tmp_q + 32'sd32768;
			end
			OP_B7: begin
				mul_a = {13'd0, up_q} - b3_q;
				mul_b = 32'd50000 >> oss_q;
			end
			OP_Q: begin
				use_div = 1'b1;
				div_n = b7_q[31] ? b7_q : (b7_q << 1);
				div_d = b4_q;
			end
			OP_PP: begin
				mul_a = pshr;
				mul_b = pshr;
			end
			OP_P1: begin
				mul_a = tmp_q;
				mul_b = 32'd3038;
			end
			OP_P2: begin
				mul_a = 32'($signed(-32'sd7357));
				mul_b = p_q;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign mul_start = (state_q == S_ISSUE) && !use_div;
	assign div_start = (state_q == S_ISSUE) && use_div;
	assign unit_done = use_div ? div_done : mul_done;

	bpc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(mres)
	);

	bpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_n), .den(div_d), .done(div_done), .quo(dres)
	);

	// post-processing of each step
	logic signed [31:0] x1t_c, den_c, q_c, b5_c, x3p_c, sum1_c, shl_c, b3_c;
	logic signed [31:0] x3q_c, pf_c;

	assign mres_s = $signed(mres);
	assign x1t_c = mres_s >>> 15;
	assign den_c = x1t_c + md;
	assign q_c = (mcs[31] ^ den_q[31]) ? 32'(-$signed(dres)) : $signed(dres);
	assign b5_c = x1_q + q_c;
	assign x3p_c = tmp_q + (mres_s >>> 11);
	assign sum1_c = (ac1 <<< 2) + x3p_c;
	assign shl_c = sum1_c <<< oss_q;
	assign b3_c = (shl_c + 32'sd2) >>> 2;
	assign x3q_c = (tmp_q + (mres_s >>> 16) + 32'sd2) >>> 2;
	assign pf_c = p_q + ((tmp_q + (mres_s >>> 16) + 32'sd3791) >>> 4);

	// result check
	logic       ok_c;
	logic [2:0] fail_nx;

	assign ok_c = !bad_q && (up_q != '0) && (p_q >= 32'sd30000) && (p_q <= 32'sd120000)
		&& (t_q >= -32'sd500) && (t_q <= 32'sd700);
	assign fail_nx = (fail_q < FAIL_MAX) ? 3'(fail_q + 1'b1) : fail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_X1T;
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			cal_d_q <= '0;
			oss_q <= 2'd2;
			held_q <= '0;
			fail_q <= '0;
			good_t_q <= 11'sd250;
			good_p_q <= 17'd101325;
			out_valid_q <= 1'b0;
			bad_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_CAL_A: cal_a_q <= cfg_data;
					CFG_CAL_B: cal_b_q <= cfg_data;
					CFG_CAL_C: cal_c_q <= cfg_data[31:0];
					CFG_CAL_D: cal_d_q <= cfg_data[31:0];
					CFG_OSS:   oss_q <= cfg_data[1:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_FINISH && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.temp_fresh)
							held_q <= in_data.raw_temp;
						bad_q <= 1'b0;
						op_q <= OP_X1T;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (unit_done) begin
						op_q <= op_t'(4'(op_q + 4'd1));
						state_q <= S_ISSUE;
						case (op_q)
							OP_X1T: if (den_c == '0) begin
								bad_q <= 1'b1;
								state_q <= S_FINISH;
							end
							OP_B4: if (mres[31:15] == '0) begin
								bad_q <= 1'b1;
								state_q <= S_FINISH;
							end
							OP_P2: state_q <= S_FINISH;
							default: begin
							end
						endcase
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
						if (ok_c) begin
							good_t_q <= t_q[10:0];
							good_p_q <= p_q[16:0];
							fail_q <= '0;
						end else begin
							fail_q <= fail_nx;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			up_q <= in_data.raw_pressure;
		if (state_q == S_WAIT && unit_done) begin
			case (op_q)
				OP_X1T: begin
					x1_q <= x1t_c;
					den_q <= den_c;
				end
				OP_X2T: begin
					b6_q <= b5_c - 32'sd4000;
					t_q <= (b5_c + 32'sd8) >>> 4;
				end
				OP_SQ:  sq_q <= mres_s >>> 12;
				OP_X1P: tmp_q <= mres_s >>> 11;
				OP_X2P: b3_q <= b3_c;
				OP_X1Q: tmp_q <= mres_s >>> 13;
				OP_X2Q: tmp_q <= x3q_c;
				OP_B4:  b4_q <= mres >> 15;
				OP_B7:  b7_q <= mres;
				OP_Q:   p_q <= b7_q[31] ? $signed(dres << 1) : $signed(dres);
				OP_PP:  tmp_q <= mres_s;
				OP_P1:  tmp_q <= mres_s >>> 16;
				OP_P2:  p_q <= pf_c;
				default: begin
				end
			endcase
		end
		if (state_q == S_FINISH && (!out_valid_q || !out_stall)) begin
			if (ok_c) begin
				out_q.temperature <= t_q[10:0];
				out_q.pressure <= p_q[16:0];
				out_q.status <= ST_OK;
			end else begin
				out_q.temperature <= good_t_q;
				out_q.pressure <= good_p_q;
				out_q.status <= (fail_nx >= FAIL_LIMIT) ? ST_REPEAT : ST_WARN;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign cfg_ready = 1'b1;
endmodule
`default_nettype wire
